/* src/column_stripe_weighted_centroid_unit_defines.svh */
// ---------------------------------------------------------------------------
// Column stripe centroid unit - assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef COLUMN_STRIPE_WEIGHTED_CENTROID_UNIT_DEFINES_SVH
`define COLUMN_STRIPE_WEIGHTED_CENTROID_UNIT_DEFINES_SVH

// same-cycle implication
`define CSWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSWC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/cswc_pkg.sv */
// ---------------------------------------------------------------------------
// cswc_pkg
// Types and fixed constants of the column stripe centroid unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cswc_pkg;

   localparam int RGB_W      = 24;
   localparam int BLUE_W     = 8;
   localparam int CENTROID_W = 20;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [RGB_W-1:0]  BLACK_RGB    = 24'h000000;
   localparam logic [RGB_W-1:0]  WHITE_RGB    = 24'hffffff;
   localparam logic [RGB_W-1:0]  TARGET_RESET = 24'hff0000;
   localparam logic [BLUE_W-1:0] BLUE_FULL    = 8'hff;

   localparam logic [CENTROID_W-1:0] CENTROID_MAX = '1;

   // word index of the target colour register
   localparam logic REG_TARGET_COLOR = 1'b0;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* src/cswc_divider.sv */
// ---------------------------------------------------------------------------
// cswc_divider
// Restoring divider, one quotient bit per cycle, saturating result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cswc_divider #(
   parameter int NUM_W = 41,
   parameter int DEN_W = 20
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [NUM_W-1:0]                      numerator,
   input  wire  [DEN_W-1:0]                      denominator,
   output logic [cswc_pkg::CENTROID_W-1:0]       quotient,
   output cswc_pkg::div_status_type              status
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
   localparam int Q_W   = cswc_pkg::CENTROID_W;

   logic [NUM_W-1:0] num_ff,   num_in;
   logic [DEN_W-1:0] den_ff,   den_in;
   logic [DEN_W-1:0] rem_ff,   rem_in;
   logic [Q_W-1:0]   quo_ff,   quo_in;
   logic             ovf_ff,   ovf_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff,  busy_in;
   logic             done_ff,  done_in;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         num_in   = numerator;
         den_in   = denominator;
         rem_in   = '0;
         quo_in   = '0;
         ovf_in   = 1'b0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = num_ff << 1;
         rem_in   = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quo_in   = {quo_ff[Q_W-2:0], fits};
         // a set bit leaving the top means the result exceeds the field
         ovf_in   = ovf_ff | quo_ff[Q_W-1];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ovf_ff   <= ovf_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = ovf_ff ? cswc_pkg::CENTROID_MAX : quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

/* src/column_stripe_weighted_centroid_unit.sv */
// Pixels are taken one per cycle while a column accumulates (one 8 x row multiply-add).
// After the bottom pixel: a setup state, then the divider runs one quotient bit
// per cycle over 2*log2(MAX_ROWS)+17 bits (41 at 4096 rows); the send state then loads
// the output register. With nothing found, setup goes straight to the send state.
// req_ready is low from the bottom pixel until the result sits in the output register.
// Synchronous reset: target colour to 0xff0000, column sums and row counter cleared.
// ---------------------------------------------------------------------------
// column_stripe_weighted_centroid_unit
// Finds the target colour in a pixel column and gives the weighted centroid row
// of the run around it, in 8-bit fractional fixed point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module column_stripe_weighted_centroid_unit #(
   parameter int MAX_ROWS = 4096
) (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [cswc_pkg::RGB_W-1:0]           req_pixel_rgb,
   input  wire                                  req_last_in_column,

   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic                                 rsp_found,
   output logic [cswc_pkg::CENTROID_W-1:0]      rsp_centroid_row_q8,

   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [cswc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [cswc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cswc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int ROW_W  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam int BW     = cswc_pkg::BLUE_W;
   localparam int PROD_W = ROW_W + BW;
   localparam int WS_W   = ROW_W + BW;
   localparam int WRS_W  = 2 * ROW_W + BW;
   localparam int NUM_W  = WRS_W + BW + 1;
   localparam int CW     = cswc_pkg::CENTROID_W;
   localparam int RGB_W  = cswc_pkg::RGB_W;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_PREP,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type          state_ff,    state_in;
   logic [RGB_W-1:0]   target_ff,   target_in;
   logic [ROW_W-1:0]   row_ff,      row_in;
   logic [WS_W-1:0]    ws_ff,       ws_in;
   logic [WRS_W-1:0]   wrs_ff,      wrs_in;
   logic               match_ff,    match_in;
   logic               closed_ff,   closed_in;
   logic               found_ff,    found_in;
   logic [CW-1:0]      res_ff,      res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [CW-1:0]      rsp_q8_ff,   rsp_q8_in;

   logic               px_beat;
   logic               px_edge;
   logic [BW-1:0]      weight;
   logic [PROD_W-1:0]  prod;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [CW-1:0]      div_quo;
   cswc_pkg::div_status_type div_status;
   logic               csr_write;

   assign px_beat   = req_valid && req_ready;
   assign px_edge   = (req_pixel_rgb == cswc_pkg::BLACK_RGB) ||
                      (req_pixel_rgb == cswc_pkg::WHITE_RGB);
   assign weight    = cswc_pkg::BLUE_FULL - req_pixel_rgb[BW-1:0];
   assign prod      = PROD_W'(weight) * PROD_W'(row_ff);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[cswc_pkg::CSR_ADDR_W-1] == cswc_pkg::REG_TARGET_COLOR);

   // rounded numerator: sum * 256 + weight/2
   assign div_num   = NUM_W'({wrs_ff, {BW{1'b0}}}) + NUM_W'(ws_ff >> 1);
   assign div_start = (state_ff == ST_PREP) && match_ff && (ws_ff != '0);

   cswc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (WS_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (ws_ff),
      .quotient    (div_quo),
      .status      (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      row_in       = row_ff;
      ws_in        = ws_ff;
      wrs_in       = wrs_ff;
      match_in     = match_ff;
      closed_in    = closed_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_q8_in    = rsp_q8_ff;

      if (csr_write) begin
         target_in = csr_pwdata[RGB_W-1:0];
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_ACCUM: begin
            if (px_beat) begin
               if (!match_ff) begin
                  if (req_pixel_rgb == target_ff) begin
                     match_in = 1'b1;
                  end
                  if (px_edge) begin
                     ws_in  = '0;
                     wrs_in = '0;
                  end else begin
                     ws_in  = ws_ff + WS_W'(weight);
                     wrs_in = wrs_ff + WRS_W'(prod);
                  end
               end else if (!closed_ff) begin
                  if (px_edge) begin
                     closed_in = 1'b1;
                  end else begin
                     ws_in  = ws_ff + WS_W'(weight);
                     wrs_in = wrs_ff + WRS_W'(prod);
                  end
               end
               row_in = (row_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : row_ff + 1'b1;
               if (req_last_in_column) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            found_in  = div_start;
            res_in    = '0;
            row_in    = '0;
            ws_in     = '0;
            wrs_in    = '0;
            match_in  = 1'b0;
            closed_in = 1'b0;
            state_in  = div_start ? ST_DIV : ST_SEND;
         end
         ST_DIV: begin
            if (div_status.done) begin
               res_in   = div_quo;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_q8_in    = res_ff;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      res_ff       <= res_in;
      rsp_found_ff <= rsp_found_in;
      rsp_q8_ff    <= rsp_q8_in;
      if (reset) begin
         state_ff     <= ST_ACCUM;
         target_ff    <= cswc_pkg::TARGET_RESET;
         row_ff       <= '0;
         ws_ff        <= '0;
         wrs_ff       <= '0;
         match_ff     <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         row_ff       <= row_in;
         ws_ff        <= ws_in;
         wrs_ff       <= wrs_in;
         match_ff     <= match_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready           = (state_ff == ST_ACCUM);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_centroid_row_q8 = rsp_q8_ff;
   assign csr_pready          = 1'b1;
   assign csr_prdata          =
      (csr_paddr[cswc_pkg::CSR_ADDR_W-1] == cswc_pkg::REG_TARGET_COLOR) ?
      cswc_pkg::CSR_DATA_W'(target_ff) : '0;

endmodule

`default_nettype wire

/* src/cswc_checker.sv */
// ---------------------------------------------------------------------------
// cswc_checker
// Port-level checks of the column stripe centroid unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "column_stripe_weighted_centroid_unit_defines.svh"

module cswc_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                req_last_in_column,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire                                rsp_found,
   input wire [cswc_pkg::CENTROID_W-1:0]     rsp_centroid_row_q8,
   input wire                                csr_pready
);

   // bottom pixel of a column stops intake while the result is worked out
   `CSWC_ASSERT_NXT(a_stall_after_last, clock, reset, req_valid && req_ready && req_last_in_column, !req_ready, "intake not stopped after bottom pixel")

   `CSWC_ASSERT_IMP(a_miss_is_zero, clock, reset, rsp_valid && !rsp_found, rsp_centroid_row_q8 == '0, "centroid nonzero on a miss")

   `CSWC_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_centroid_row_q8), "result beat changed while stalled")

   `CSWC_ASSERT_IMP(a_pready_high, clock, reset, 1'b1, csr_pready, "register port stalled")

endmodule

bind column_stripe_weighted_centroid_unit cswc_checker u_cswc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_last_in_column  (req_last_in_column),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_found           (rsp_found),
   .rsp_centroid_row_q8 (rsp_centroid_row_q8),
   .csr_pready          (csr_pready)
);

`default_nettype wire

/* tb/sv/tb_column_stripe_weighted_centroid_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_column_stripe_weighted_centroid_unit
// Streams pixel columns through the centroid unit under a range of target
// colours. A local tracker of the run sums predicts each column's found flag
// and centroid, and every result beat is checked against it in order.
// ---------------------------------------------------------------------------

module tb_column_stripe_weighted_centroid_unit;

   localparam int RGB_W      = cswc_pkg::RGB_W;
   localparam int BLUE_W     = cswc_pkg::BLUE_W;
   localparam int CENTROID_W = cswc_pkg::CENTROID_W;
   localparam int CSR_DATA_W = cswc_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W = cswc_pkg::CSR_ADDR_W;

   localparam logic [RGB_W-1:0]      BLACK_RGB    = cswc_pkg::BLACK_RGB;
   localparam logic [RGB_W-1:0]      WHITE_RGB    = cswc_pkg::WHITE_RGB;
   localparam logic [RGB_W-1:0]      TARGET_RESET = cswc_pkg::TARGET_RESET;
   localparam logic [BLUE_W-1:0]     BLUE_FULL    = cswc_pkg::BLUE_FULL;
   localparam logic [CENTROID_W-1:0] CENTROID_MAX = cswc_pkg::CENTROID_MAX;

   localparam int COL_ROWS   = 4096;
   localparam int DRAIN_WAIT = 60;   // divider run plus margin
   localparam logic [CSR_ADDR_W-1:0] TARGET_ADDR =
      CSR_ADDR_W'({cswc_pkg::REG_TARGET_COLOR, 2'b00});

   typedef logic [RGB_W-1:0] pixel_column_type[$];

   typedef struct packed {
      logic                  found;
      logic [CENTROID_W-1:0] row_q8;
   } column_result_type;

   logic clock              = 1'b0;
   logic reset              = 1'b1;
   logic req_valid          = 1'b0;
   logic [RGB_W-1:0] req_pixel_rgb = '0;
   logic req_last_in_column = 1'b0;
   logic rsp_ready          = 1'b1;
   logic csr_psel           = 1'b0;
   logic csr_penable        = 1'b0;
   logic csr_pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;

   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_found;
   logic [CENTROID_W-1:0] rsp_centroid_row_q8;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // tracker of the column being streamed
   logic [RGB_W-1:0] model_target = TARGET_RESET;
   int unsigned      row_pos      = 0;
   longint unsigned  run_weight   = 0;
   longint unsigned  run_moment   = 0;
   bit               target_hit   = 0;
   bit               run_ended    = 0;

   column_result_type centroid_q[$];
   int  mismatches     = 0;
   int  pixels_sent    = 0;
   int  columns_done   = 0;
   int  targets_tried  = 0;
   bit  idle_on        = 1;

   column_stripe_weighted_centroid_unit #(.MAX_ROWS(COL_ROWS)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_rgb       (req_pixel_rgb),
      .req_last_in_column  (req_last_in_column),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_centroid_row_q8 (rsp_centroid_row_q8),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("Timed out with %0d column results outstanding", centroid_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Advances the run sums by one pixel; returns 1 when the column closes.
   function automatic bit track_pixel(input logic [RGB_W-1:0] rgb, input logic last,
                                      output column_result_type res);
      longint unsigned wgt;
      longint unsigned q;
      bit border;
      bit take;
      res    = '0;
      border = (rgb == BLACK_RGB) || (rgb == WHITE_RGB);
      wgt    = BLUE_FULL - rgb[BLUE_W-1:0];
      take   = 0;
      if (!target_hit) begin
         target_hit = (rgb == model_target);
         if (border) begin
            run_weight = 0;
            run_moment = 0;
         end
         take = !border;
      end else if (!run_ended) begin
         run_ended = border;
         take      = !border;
      end
      if (take) begin
         run_weight += wgt;
         run_moment += wgt * row_pos;
      end
      row_pos = (row_pos + 1) % COL_ROWS;
      if (!last) return 0;
      if (target_hit && run_weight != 0) begin
         q          = (run_moment * 256 + run_weight / 2) / run_weight;
         res.found  = 1'b1;
         res.row_q8 = (q > CENTROID_MAX) ? CENTROID_MAX : CENTROID_W'(q);
      end
      row_pos    = 0;
      run_weight = 0;
      run_moment = 0;
      target_hit = 0;
      run_ended  = 0;
      return 1;
   endfunction

   task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic last);
      column_result_type res;
      if (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_pixel_rgb      <= rgb;
      req_last_in_column <= last;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      if (track_pixel(rgb, last, res)) centroid_q.push_back(res);
   endtask

   task automatic send_column(input pixel_column_type col);
      for (int i = 0; i < col.size(); i++) send_pixel(col[i], i == col.size() - 1);
   endtask

   // Sender holds off until every column result is back and the unit is quiet.
   task automatic settle_columns();
      req_valid <= 1'b0;
      while (centroid_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write the target register, then read it back.
   task automatic set_target(input logic [RGB_W-1:0] colour);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TARGET_ADDR;
      csr_pwdata  <= CSR_DATA_W'(colour);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_target = colour;
      targets_tried++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(colour)) begin
         $error("target_color readback: expected %06h, got %08h", colour, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [RGB_W-1:0] pick_target();
      case ($urandom_range(5))
         0:       return BLACK_RGB;
         1:       return WHITE_RGB;
         2:       return TARGET_RESET;
         3:       return {16'($urandom), BLUE_FULL};
         default: return RGB_W'($urandom);
      endcase
   endfunction

   // Mostly tidy columns holding the target once inside runs; the rest is noise.
   function automatic pixel_column_type make_column();
      pixel_column_type col;
      int len;
      int hit_at;
      int roll;
      bit tidy;
      tidy   = $urandom_range(99) < 80;
      len    = ($urandom_range(99) < 90) ? $urandom_range(1, 40) : $urandom_range(41, 200);
      hit_at = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(99);
         if (tidy && i == hit_at)              col.push_back(model_target);
         else if (roll < (tidy ? 5 : 12))      col.push_back(BLACK_RGB);
         else if (roll < (tidy ? 10 : 24))     col.push_back(WHITE_RGB);
         else if (!tidy && roll < 28)          col.push_back(model_target);
         else if (roll < 40)                   col.push_back({16'($urandom), BLUE_FULL});
         else                                  col.push_back(RGB_W'($urandom));
      end
      return col;
   endfunction

   always @(posedge clock) begin : check_results
      column_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         columns_done++;
         if (centroid_q.size() == 0) begin
            $error("result beat with nothing expected: found=%0b centroid_row_q8=%05h",
                   rsp_found, rsp_centroid_row_q8);
            mismatches++;
         end else begin
            want = centroid_q.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_found);
               mismatches++;
            end
            if (rsp_centroid_row_q8 !== want.row_q8) begin
               $error("centroid_row_q8: expected %05h, got %05h",
                      want.row_q8, rsp_centroid_row_q8);
               mismatches++;
            end
         end
      end
      rsp_ready <= !(idle_on && $urandom_range(99) < 7);
   end

   // Target as it comes out of reset: lone match, no match, runs cut by borders.
   task automatic test_reset_target();
      pixel_column_type col;
      col = {TARGET_RESET};
      send_column(col);
      col = {24'h123456};
      send_column(col);
      col = {WHITE_RGB, 24'h804020, TARGET_RESET, 24'h10ff80, BLACK_RGB,
             24'h112233, TARGET_RESET, 24'h000001};
      send_column(col);
   endtask

   // Black or white target: the match pixel clears the sums, the run follows it.
   task automatic test_border_targets();
      pixel_column_type col;
      settle_columns();
      set_target(BLACK_RGB);
      col = {24'h404040, BLACK_RGB, 24'h102030, 24'h2030c0, WHITE_RGB, 24'h111111};
      send_column(col);
      settle_columns();
      set_target(WHITE_RGB);
      col = {24'h808080, WHITE_RGB, 24'h7f7f7f, BLACK_RGB};
      send_column(col);
      col = {WHITE_RGB};
      send_column(col);
   endtask

   // Full blue byte gives zero weight; a zero sum must clear the flag.
   task automatic test_blue_full_target();
      pixel_column_type col;
      settle_columns();
      set_target(24'h1234ff);
      col = {24'h1234ff, 24'haabbff, WHITE_RGB};
      send_column(col);
      col = {24'h5555ff, 24'h1234ff, 24'h010203};
      send_column(col);
   endtask

   task automatic test_random_columns(input int budget);
      int stop_at;
      int phase;
      stop_at = pixels_sent + budget;
      phase   = 0;
      while (pixels_sent < stop_at) begin
         settle_columns();
         idle_on = (phase != 0);   // first batch runs flat out
         set_target(pick_target());
         repeat ($urandom_range(6, 14)) send_column(make_column());
         phase++;
      end
      idle_on = 1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_target();
      test_border_targets();
      test_blue_full_target();
      test_random_columns(1100);
      settle_columns();
      $display("Streamed %0d pixels into %0d column results over %0d target colours,",
               pixels_sent, columns_done, targets_tried);
      $display("including black, white and full-blue targets and zero-weight columns.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/cswc_pkg.sv
src/cswc_divider.sv
src/column_stripe_weighted_centroid_unit.sv
src/cswc_checker.sv
tb/sv/tb_column_stripe_weighted_centroid_unit.sv
